### hdl/haat_pkg.sv
// ----------------------------------------------------------------------------
// Hashed aging address table package
// Shared sizes, operation codes and the stored entry layout.
// ----------------------------------------------------------------------------
package haat_pkg;

   localparam int BUCKET_BITS = 6;
   localparam int WAY_BITS    = 2;
   localparam int BUCKETS     = 1 << BUCKET_BITS;
   localparam int WAYS        = 1 << WAY_BITS;
   localparam int ENTRIES     = BUCKETS * WAYS;
   localparam int INDEX_BITS  = BUCKET_BITS + WAY_BITS;

   localparam int OP_BITS     = 3;
   localparam int ADDR_BITS   = 32;
   localparam int KIND_BITS   = 2;
   localparam int SLOT_BITS   = 8;
   localparam int TALLY_BITS  = 9;
   localparam int TIME_BITS   = 16;

   localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;
   localparam logic [TIME_BITS-1:0]  AGE_LIMIT_RESET = TIME_BITS'(30);

   localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 3'd1;
   localparam logic [OP_BITS-1:0] OP_COUNT  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_TICK   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_SWEEP  = 3'd4;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic [KIND_BITS-1:0] kind;
      logic [TIME_BITS-1:0] stamp;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

### hdl/haat_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module haat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/hashed_aging_address_table_unit.sv
// ----------------------------------------------------------------------------
// Hashed aging address table unit
// Bucketed address table with insert, lookup, type count, tick and aging sweep.
// ----------------------------------------------------------------------------
// Entries live in one RAM with a single read port, and one compare and age
// unit checks the entry read in the previous cycle. Insert and lookup read the
// ways of the bucket one per cycle, then pass through the tail and finish
// states; finish waits while an earlier result is still stalled, and no new
// beat is taken until the sequencer is back in idle. Count and sweep walk
// every entry through the same read port. Tick and unknown codes skip the
// scan. The result is held in an output register until it is taken.
module hashed_aging_address_table_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [haat_pkg::OP_BITS-1:0]         req_op,
   input  logic [haat_pkg::ADDR_BITS-1:0]       req_addr,
   input  logic [haat_pkg::KIND_BITS-1:0]       req_entry_type,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [haat_pkg::SLOT_BITS-1:0]       rsp_slot,
   output logic [haat_pkg::TALLY_BITS-1:0]      rsp_tally,
   output logic                                 rsp_status,
   input  logic                                 csr_wr_en,
   input  logic [haat_pkg::TIME_BITS-1:0]       csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_FINISH
   } state_type;

   state_type                            state_ff, state_in;
   logic [haat_pkg::ENTRIES-1:0]         valid_ff, valid_in;
   logic [haat_pkg::TIME_BITS-1:0]       seconds_ff, seconds_in;
   logic [haat_pkg::TIME_BITS-1:0]       age_limit_ff, age_limit_in;
   logic [haat_pkg::OP_BITS-1:0]         op_ff, op_in;
   logic [haat_pkg::ADDR_BITS-1:0]       addr_ff, addr_in;
   logic [haat_pkg::KIND_BITS-1:0]       kind_ff, kind_in;
   logic [haat_pkg::INDEX_BITS-1:0]      cnt_ff, cnt_in;
   logic                                 chk_vld_ff, chk_vld_in;
   logic [haat_pkg::INDEX_BITS-1:0]      chk_idx_ff, chk_idx_in;
   logic                                 hit_ff, hit_in;
   logic [haat_pkg::INDEX_BITS-1:0]      hit_idx_ff, hit_idx_in;
   logic                                 free_ff, free_in;
   logic [haat_pkg::INDEX_BITS-1:0]      free_idx_ff, free_idx_in;
   logic [haat_pkg::TALLY_BITS-1:0]      tally_ff, tally_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic [haat_pkg::SLOT_BITS-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [haat_pkg::TALLY_BITS-1:0]      rsp_tally_ff, rsp_tally_in;
   logic                                 rsp_status_ff, rsp_status_in;

   logic                                 full_scan;
   logic [haat_pkg::INDEX_BITS-1:0]      scan_base;
   logic [haat_pkg::INDEX_BITS-1:0]      scan_last;
   logic                                 ram_wr_en;
   logic [haat_pkg::INDEX_BITS-1:0]      ram_wr_addr;
   haat_pkg::entry_type                  ram_wr_data;
   logic                                 ram_rd_en;
   logic [haat_pkg::INDEX_BITS-1:0]      ram_rd_addr;
   haat_pkg::entry_type                  ram_rd_data;
   logic                                 chk_valid_bit;
   logic                                 chk_match;
   logic [haat_pkg::TIME_BITS-1:0]       chk_age;

   haat_ram #(
      .WIDTH (haat_pkg::ENTRY_BITS),
      .DEPTH (haat_pkg::ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign full_scan = (op_ff == haat_pkg::OP_COUNT) || (op_ff == haat_pkg::OP_SWEEP);
   assign scan_base = full_scan ? '0
                      : {addr_ff[haat_pkg::BUCKET_BITS-1:0], {haat_pkg::WAY_BITS{1'b0}}};
   assign scan_last = full_scan ? haat_pkg::INDEX_BITS'(haat_pkg::ENTRIES - 1)
                      : haat_pkg::INDEX_BITS'(haat_pkg::WAYS - 1);
   assign ram_rd_addr = scan_base + cnt_ff;

   assign chk_valid_bit = valid_ff[chk_idx_ff];
   assign chk_match = chk_valid_bit && (ram_rd_data.address == addr_ff)
                      && (ram_rd_data.kind == kind_ff);
   assign chk_age = seconds_ff - ram_rd_data.stamp;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      seconds_in    = seconds_ff;
      age_limit_in  = csr_wr_en ? csr_wr_data : age_limit_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      kind_in       = kind_ff;
      cnt_in        = cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      tally_in      = tally_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tally_in  = rsp_tally_ff;
      rsp_status_in = rsp_status_ff;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = '{address: addr_ff, kind: kind_ff, stamp: seconds_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               addr_in  = req_addr;
               kind_in  = req_entry_type;
               cnt_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               tally_in = '0;
               if ((req_op == haat_pkg::OP_INSERT) || (req_op == haat_pkg::OP_LOOKUP)
                   || (req_op == haat_pkg::OP_COUNT) || (req_op == haat_pkg::OP_SWEEP)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            ram_rd_en  = 1'b1;
            chk_vld_in = 1'b1;
            chk_idx_in = ram_rd_addr;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == scan_last) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_slot_in   = '0;
               rsp_tally_in  = '0;
               rsp_status_in = 1'b0;
               state_in      = S_IDLE;
               unique case (op_ff)
                  haat_pkg::OP_INSERT: begin
                     if (hit_ff) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = hit_idx_ff;
                        rsp_found_in = 1'b1;
                        rsp_slot_in  = haat_pkg::SLOT_BITS'(hit_idx_ff);
                     end else if (free_ff) begin
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = free_idx_ff;
                        valid_in[free_idx_ff] = 1'b1;
                        rsp_slot_in           = haat_pkg::SLOT_BITS'(free_idx_ff);
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  haat_pkg::OP_LOOKUP: begin
                     rsp_found_in = hit_ff;
                     rsp_slot_in  = hit_ff ? haat_pkg::SLOT_BITS'(hit_idx_ff) : '0;
                  end
                  haat_pkg::OP_COUNT,
                  haat_pkg::OP_SWEEP: begin
                     rsp_tally_in = tally_ff;
                  end
                  haat_pkg::OP_TICK: begin
                     seconds_in = seconds_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (chk_vld_ff) begin
         if (full_scan) begin
            if (op_ff == haat_pkg::OP_COUNT) begin
               if (chk_valid_bit && (ram_rd_data.kind == kind_ff) && (tally_ff != haat_pkg::TALLY_MAX)) begin
                  tally_in = tally_ff + 1'b1;
               end
            end else if (chk_valid_bit && (chk_age > age_limit_ff)) begin
               valid_in[chk_idx_ff] = 1'b0;
               if (tally_ff != haat_pkg::TALLY_MAX) begin
                  tally_in = tally_ff + 1'b1;
               end
            end
         end else begin
            if (chk_match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
            end
            if (!chk_valid_bit && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         seconds_ff   <= '0;
         age_limit_ff <= haat_pkg::AGE_LIMIT_RESET;
         chk_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         seconds_ff   <= seconds_in;
         age_limit_ff <= age_limit_in;
         chk_vld_ff   <= chk_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      kind_ff       <= kind_in;
      cnt_ff        <= cnt_in;
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      tally_ff      <= tally_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tally_ff  <= rsp_tally_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_tally  = rsp_tally_ff;
   assign rsp_status = rsp_status_ff;

`ifndef ASSERT_OFF
   a_check_follows_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> ($past(state_ff) == S_SCAN))
      else $error("entry check without a preceding scan read");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("request beat taken but sequencer stayed idle");

   a_idle_keeps_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(valid_ff))
      else $error("table valid bits changed while idle");

   a_dropped_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (!rsp_found_ff && (rsp_slot_ff == '0)))
      else $error("dropped insert reports a match or slot");
`endif

endmodule
